/* rtl/bounding_sphere_from_points_core_defines.svh */
// Assertion helpers for the bounding sphere core
`ifndef BOUNDING_SPHERE_FROM_POINTS_CORE_DEFINES_SVH
`define BOUNDING_SPHERE_FROM_POINTS_CORE_DEFINES_SVH

// Same-cycle implication
`define BSP_ASSERT_NOW(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Next-cycle implication
`define BSP_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

/* rtl/bsp_pkg.sv */
`default_nettype none
package bsp_pkg;
  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int COORD_W    = 24;
  localparam int RAD_W      = 25;
  localparam int SQ_W       = 2 * RAD_W - 1;   // one axis squared
  localparam int DIST_W     = 2 * RAD_W;       // sum of three squares
  localparam int REM_W      = RAD_W + 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    point_t           centre;
    logic [CNT_W-1:0] count;
    logic             dropped;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  // floor((a + b) / 2) on 24-bit signed values
  function automatic logic signed [COORD_W-1:0] half_sum(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    return s[COORD_W:1];
  endfunction
endpackage
`default_nettype wire

/* rtl/bsp_ifs.sv */
`default_nettype none
interface bsp_point_if;
  logic        valid;
  logic        ready;
  logic [23:0] coord_x;
  logic [23:0] coord_y;
  logic [23:0] coord_z;
  logic        last_point;
  modport source (output valid, coord_x, coord_y, coord_z, last_point, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface

interface bsp_sphere_if;
  logic        valid;
  logic        ready;
  logic [23:0] centre_x;
  logic [23:0] centre_y;
  logic [23:0] centre_z;
  logic [24:0] radius_out;
  logic        overflow_flag;
  modport source (output valid, centre_x, centre_y, centre_z, radius_out, overflow_flag,
                  input ready);
  modport sink   (input valid, centre_x, centre_y, centre_z, radius_out, overflow_flag,
                  output ready);
endinterface
`default_nettype wire

/* rtl/bounding_sphere_from_points_core.sv */
// Flow: after the last point of a set, its N stored points are read back through a
// three-stage distance pipe (read, square, accumulate), then a bit-serial root runs.
// Throughput: one point per cycle while a set is loading; the distance pass, root and
// result hold then keep the input off until the sphere is in the output register.
// Reset: synchronous active-high rst clears set state, job queue and output valid.
`default_nettype none
module bounding_sphere_from_points_core (
  input  wire logic     clk,
  input  wire logic     rst,
  bsp_point_if.sink     pt,
  bsp_sphere_if.source  sph
);
  import bsp_pkg::*;
  `include "bounding_sphere_from_points_core_defines.svh"

  logic    back_busy, job_pop, job_valid;
  job_t    job;
  rd_req_t rd_req;
  point_t  rd_data;

  bsp_front u_front (
    .clk, .rst, .pt, .back_busy, .job_pop, .job_valid, .job, .rd_req, .rd_data
  );

  bsp_back u_back (
    .clk, .rst, .job_valid, .job, .job_pop, .back_busy, .rd_req, .rd_data, .sph
  );

  `BSP_ASSERT_NOW(a_no_accept_busy, pt.valid && pt.ready, !back_busy, "point taken while busy")
  `BSP_ASSERT_NEXT(a_last_blocks, pt.valid && pt.ready && pt.last_point, !pt.ready, "no stall after last point")
  `BSP_ASSERT_NOW(a_pop_valid, job_pop, job_valid, "pop from empty queue")
endmodule
`default_nettype wire

/* rtl/bsp_front.sv */
`default_nettype none
module bsp_front (
  input  wire logic           clk,
  input  wire logic           rst,
  bsp_point_if.sink           pt,
  input  wire logic           back_busy,
  input  wire logic           job_pop,
  output logic                job_valid,
  output bsp_pkg::job_t       job,
  input  wire bsp_pkg::rd_req_t rd_req,
  output bsp_pkg::point_t     rd_data
);
  import bsp_pkg::*;

  point_t           mem [MAX_POINTS];
  logic [CNT_W-1:0] count;
  point_t           lo, hi, lo_next, hi_next, in_pt;
  logic             dropped;
  logic             accept, room, first;
  job_t             q [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       q_cnt;
  job_t             new_job;

  assign in_pt    = '{x: pt.coord_x, y: pt.coord_y, z: pt.coord_z};
  assign pt.ready = (q_cnt == 2'd0) && !back_busy;
  assign accept   = pt.valid && pt.ready;
  assign room     = count < CNT_W'(MAX_POINTS);
  assign first    = count == '0;

  // running box, loaded by the first point
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (room) begin
      if (first) begin
        lo_next = in_pt;
        hi_next = in_pt;
      end else begin
        if ($signed(in_pt.x) < $signed(lo.x)) lo_next.x = in_pt.x;
        if ($signed(in_pt.y) < $signed(lo.y)) lo_next.y = in_pt.y;
        if ($signed(in_pt.z) < $signed(lo.z)) lo_next.z = in_pt.z;
        if ($signed(in_pt.x) > $signed(hi.x)) hi_next.x = in_pt.x;
        if ($signed(in_pt.y) > $signed(hi.y)) hi_next.y = in_pt.y;
        if ($signed(in_pt.z) > $signed(hi.z)) hi_next.z = in_pt.z;
      end
    end
  end

  // job built on the last point of a set
  always_comb begin
    new_job.centre.x = half_sum(lo_next.x, hi_next.x);
    new_job.centre.y = half_sum(lo_next.y, hi_next.y);
    new_job.centre.z = half_sum(lo_next.z, hi_next.z);
    new_job.count    = room ? count + CNT_W'(1) : count;
    new_job.dropped  = dropped || !room;
  end

  // set tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
      lo      <= '0;
      hi      <= '0;
    end else if (accept) begin
      if (pt.last_point) begin
        count   <= '0;
        dropped <= 1'b0;
        lo      <= '0;
        hi      <= '0;
      end else begin
        count   <= new_job.count;
        dropped <= new_job.dropped;
        lo      <= lo_next;
        hi      <= hi_next;
      end
    end
  end

  // point store
  always_ff @(posedge clk) begin
    if (accept && room) mem[count[ADDR_W-1:0]] <= in_pt;
    if (rd_req.en) rd_data <= mem[rd_req.addr];
  end

  // job queue
  always_ff @(posedge clk) begin
    if (accept && pt.last_point) q[wr_ptr] <= new_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      if (accept && pt.last_point) wr_ptr <= !wr_ptr;
      if (job_pop) rd_ptr <= !rd_ptr;
      q_cnt <= q_cnt + 2'(accept && pt.last_point) - 2'(job_pop);
    end
  end

  assign job_valid = q_cnt != 2'd0;
  assign job       = q[rd_ptr];
endmodule
`default_nettype wire

/* rtl/bsp_back.sv */
`default_nettype none
module bsp_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  input  wire bsp_pkg::job_t  job,
  output logic                job_pop,
  output logic                back_busy,
  output bsp_pkg::rd_req_t    rd_req,
  input  wire bsp_pkg::point_t rd_data,
  bsp_sphere_if.source        sph
);
  import bsp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;
  localparam int STEP_W = $clog2(RAD_W);

  logic [1:0]        state;
  job_t              cur;
  logic [CNT_W-1:0]  idx;
  logic              s1_v, s2_v;
  logic [SQ_W-1:0]   sq_x, sq_y, sq_z;
  logic [DIST_W-1:0] best, sq_sum, n;
  logic [REM_W-1:0]  rem;
  logic [REM_W+1:0]  rem_sh, trial;
  logic [RAD_W-1:0]  root;
  logic [STEP_W-1:0] step;
  logic signed [COORD_W:0] dx, dy, dz;
  logic              issue;

  assign back_busy = state != ST_IDLE;
  assign job_pop   = (state == ST_IDLE) && job_valid;
  assign issue     = (state == ST_SCAN) && (idx < cur.count);
  assign rd_req    = '{en: issue, addr: idx[ADDR_W-1:0]};

  // distance pipeline: read, square, accumulate
  assign dx     = {rd_data.x[COORD_W-1], rd_data.x} - {cur.centre.x[COORD_W-1], cur.centre.x};
  assign dy     = {rd_data.y[COORD_W-1], rd_data.y} - {cur.centre.y[COORD_W-1], cur.centre.y};
  assign dz     = {rd_data.z[COORD_W-1], rd_data.z} - {cur.centre.z[COORD_W-1], cur.centre.z};
  assign sq_sum = DIST_W'(sq_x) + DIST_W'(sq_y) + DIST_W'(sq_z);

  always_ff @(posedge clk) begin
    if (s1_v) begin
      sq_x <= SQ_W'(dx * dx);
      sq_y <= SQ_W'(dy * dy);
      sq_z <= SQ_W'(dz * dz);
    end
  end

  // integer root, one result bit per cycle
  assign rem_sh = {rem, n[DIST_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      sph.valid <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      if (sph.valid && sph.ready) sph.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            idx   <= '0;
            best  <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) idx <= idx + CNT_W'(1);
          if (s2_v && sq_sum > best) best <= sq_sum;
          if (!issue && !s1_v && !s2_v) begin
            n     <= best;
            rem   <= '0;
            root  <= '0;
            step  <= '0;
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          n <= n << 2;
          if (rem_sh >= trial) begin
            rem  <= REM_W'(rem_sh - trial);
            root <= {root[RAD_W-2:0], 1'b1};
          end else begin
            rem  <= REM_W'(rem_sh);
            root <= {root[RAD_W-2:0], 1'b0};
          end
          step <= step + STEP_W'(1);
          if (step == STEP_W'(RAD_W - 1)) state <= ST_HOLD;
        end
        ST_HOLD: begin
          if (!sph.valid) begin
            sph.valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_HOLD && !sph.valid) begin
      sph.centre_x      <= cur.centre.x;
      sph.centre_y      <= cur.centre.y;
      sph.centre_z      <= cur.centre.z;
      sph.radius_out    <= root;
      sph.overflow_flag <= cur.dropped;
    end
  end
endmodule
`default_nettype wire
